// ----- rtl/core/pwt_pkg.sv -----
// Shared constants, codes and control/status structs of the partition window table.
// No dependencies; every other file of the block imports this package.
package pwt_pkg;

  // Slot store size and derived widths
  localparam int MaxSlots = 16;
  localparam int SlotW    = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int CountW   = $clog2(MaxSlots + 1);

  // Field widths
  localparam int SectorW = 13;
  localparam int ByteW   = 64;
  localparam int DiskW   = 8;
  localparam int IdxW    = 8;

  // Sector size reset value
  localparam logic [SectorW-1:0] SectorReset = SectorW'(512);

  // Configuration register indexes
  localparam logic CfgPata = 1'b0;
  localparam logic CfgSata = 1'b1;

  typedef enum logic [1:0] {
    ModeRegister = 2'd0,
    ModeRemove   = 2'd1,
    ModeRead     = 2'd2,
    ModeWrite    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StatOk    = 3'd0,
    StatRange = 3'd1,
    StatFull  = 3'd2,
    StatNoDev = 3'd3,
    StatNoSpc = 3'd4
  } status_e;

  // Result forming step requested by the controller
  typedef enum logic [2:0] {
    FinNone,
    FinRange,
    FinFull,
    FinRegister,
    FinRemove,
    FinAccess
  } fin_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input item
    logic chk;       // range check and last sector plus one
    logic mul_en;    // one partial product step
    logic mul_hi;    // upper 32 bits of the operand
    logic mul_end;   // operand is the window end, else window start
    logic scan_inc;  // advance the slot scan
    logic rm_step;   // test one slot for removal and advance
    logic rd;        // read the addressed slot
    logic acc_chk;   // offset against window length
    fin_e fin;       // form the result
    logic out_load;  // move the result to the output register
  } pwt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;       // register range check failed
    logic ovf;       // window end overflows 64 bits
    logic scan_end;  // scan reached the fill count
    logic slot_free; // scanned slot is inactive
    logic full;      // fill count at capacity
  } pwt_stat_t;

endpackage

// ----- rtl/core/pwt_ctrl.sv -----
// Sequencer of the partition window table: one item at a time through the datapath.
// Depends on pwt_pkg for modes, commands and status.
module pwt_ctrl
  import pwt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mode_e     mode_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pwt_stat_t stat_i,
  output pwt_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StRChk,
    StRMulSl,
    StRMulSh,
    StRMulEl,
    StRMulEh,
    StROvf,
    StRScan,
    StRmScan,
    StARead,
    StAChk,
    StAFin,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // Decode state into next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.fin = FinNone;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (mode_i) inside
            ModeRegister:        state_d = StRChk;
            ModeRemove:          state_d = StRmScan;
            ModeRead, ModeWrite: state_d = StARead;
            default:             state_d = StIdle;
          endcase
        end
      end
      StRChk: begin
        cmd_o.chk = 1'b1;
        state_d   = StRMulSl;
      end
      StRMulSl: begin
        if (stat_i.bad) begin
          cmd_o.fin = FinRange;
          state_d   = StDone;
        end else begin
          cmd_o.mul_en = 1'b1;
          state_d      = StRMulSh;
        end
      end
      StRMulSh: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
        state_d      = StRMulEl;
      end
      StRMulEl: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_end = 1'b1;
        state_d       = StRMulEh;
      end
      StRMulEh: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_hi  = 1'b1;
        cmd_o.mul_end = 1'b1;
        state_d       = StROvf;
      end
      StROvf: begin
        if (stat_i.ovf) begin
          cmd_o.fin = FinRange;
          state_d   = StDone;
        end else begin
          state_d = StRScan;
        end
      end
      // Take the first inactive slot, else append, else fail
      StRScan: begin
        if (stat_i.scan_end) begin
          cmd_o.fin = stat_i.full ? FinFull : FinRegister;
          state_d   = StDone;
        end else if (stat_i.slot_free) begin
          cmd_o.fin = FinRegister;
          state_d   = StDone;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      StRmScan: begin
        if (stat_i.scan_end) begin
          cmd_o.fin = FinRemove;
          state_d   = StDone;
        end else begin
          cmd_o.rm_step = 1'b1;
        end
      end
      StARead: begin
        cmd_o.rd = 1'b1;
        state_d  = StAChk;
      end
      StAChk: begin
        cmd_o.acc_chk = 1'b1;
        state_d       = StAFin;
      end
      StAFin: begin
        cmd_o.fin = FinAccess;
        state_d   = StDone;
      end
      // Hold the result until the output register frees up
      StDone: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/pwt_dp.sv -----
// Datapath of the partition window table: slot store, sector registers, shared
// 32x13 multiplier, access arithmetic and the result/output registers. Uses pwt_pkg.
module pwt_dp
  import pwt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwt_cmd_t           cmd_i,
  output pwt_stat_t          stat_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [SectorW-1:0] cfg_data_i,
  // input item
  input  mode_e              mode_i,
  input  logic [IdxW-1:0]    slot_index_i,
  input  logic [DiskW-1:0]   disk_number_i,
  input  logic               disk_is_parallel_i,
  input  logic [ByteW-1:0]   first_sector_i,
  input  logic [ByteW-1:0]   last_sector_i,
  input  logic [ByteW-1:0]   disk_sector_total_i,
  input  logic [ByteW-1:0]   byte_offset_i,
  input  logic [ByteW-1:0]   byte_count_i,
  // result item
  output status_e            status_o,
  output logic [IdxW-1:0]    slot_used_o,
  output logic [ByteW-1:0]   absolute_address_o,
  output logic [ByteW-1:0]   transfer_bytes_o,
  output logic [DiskW-1:0]   target_disk_o,
  output logic               target_is_parallel_o
);

  // Sector size registers
  logic [SectorW-1:0] pata_q, sata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pata_q <= SectorReset;
      sata_q <= SectorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPata: pata_q <= cfg_data_i;
        CfgSata: sata_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured item
  logic               is_write_q;
  logic [IdxW-1:0]    slot_index_q;
  logic [DiskW-1:0]   disk_q;
  logic               par_q;
  logic [ByteW-1:0]   first_q, last_q, total_q, off_q, cnt_q;

  // Working registers
  logic               bad_q, ovf_q;
  logic [ByteW-1:0]   lastp1_q, start_q, end_q;
  logic               nodev_q, past_q;
  logic [ByteW-1:0]   rd_start_q, rd_len_q, rem_q;
  logic [DiskW-1:0]   rd_disk_q;
  logic               rd_par_q;

  // Slot store and scan
  logic [MaxSlots-1:0] active_q;
  logic [DiskW-1:0]    disk_arr_q  [MaxSlots];
  logic                par_arr_q   [MaxSlots];
  logic [ByteW-1:0]    start_arr_q [MaxSlots];
  logic [ByteW-1:0]    len_arr_q   [MaxSlots];
  logic [CountW-1:0]   used_q, idx_q;
  logic [SlotW-1:0]    scan_sel, acc_sel;

  // Result and output registers
  status_e            res_status_q, out_status_q;
  logic [IdxW-1:0]    res_slot_q, out_slot_q;
  logic [ByteW-1:0]   res_addr_q, out_addr_q;
  logic [ByteW-1:0]   res_xfer_q, out_xfer_q;
  logic [DiskW-1:0]   res_disk_q, out_disk_q;
  logic               res_par_q, out_par_q;

  logic [SectorW-1:0] ss;
  logic [31:0]        mul_a;
  logic [ByteW-1:0]   mul_x;
  logic [44:0]        mprod;
  logic [12:0]        dst_carry;
  logic [45:0]        msum;
  logic               acc_in_range;
  logic               rm_match;

  assign ss        = par_q ? pata_q : sata_q;
  assign scan_sel  = idx_q[SlotW-1:0];
  assign acc_sel   = slot_index_q[SlotW-1:0];

  // Shared multiplier: 32-bit half of start or end operand times sector size
  assign mul_x     = cmd_i.mul_end ? lastp1_q : first_q;
  assign mul_a     = cmd_i.mul_hi ? mul_x[63:32] : mul_x[31:0];
  assign mprod     = {13'b0, mul_a} * {32'b0, ss};
  assign dst_carry = cmd_i.mul_end ? end_q[44:32] : start_q[44:32];
  assign msum      = {1'b0, mprod} + {33'b0, dst_carry};

  assign acc_in_range = 32'(slot_index_q) < 32'(used_q);
  assign rm_match     = active_q[scan_sel] && (disk_arr_q[scan_sel] == disk_q) &&
                        (par_arr_q[scan_sel] == par_q);

  assign stat_o.bad       = bad_q;
  assign stat_o.ovf       = ovf_q;
  assign stat_o.scan_end  = idx_q >= used_q;
  assign stat_o.slot_free = !active_q[scan_sel];
  assign stat_o.full      = used_q == CountW'(MaxSlots);

  // Control state of the slot store: active bits, fill count, scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      used_q   <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.load) idx_q <= '0;
      if (cmd_i.scan_inc) idx_q <= idx_q + 1'b1;
      if (cmd_i.rm_step) begin
        if (rm_match) active_q[scan_sel] <= 1'b0;
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.fin == FinRegister) begin
        active_q[scan_sel] <= 1'b1;
        if (idx_q == used_q) used_q <= used_q + 1'b1;
      end
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin == FinRegister) begin
      disk_arr_q[scan_sel]  <= disk_q;
      par_arr_q[scan_sel]   <= par_q;
      start_arr_q[scan_sel] <= start_q;
      len_arr_q[scan_sel]   <= end_q - start_q;
    end
  end

  // Capture the item and run the arithmetic steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_write_q   <= (mode_i == ModeWrite);
      slot_index_q <= slot_index_i;
      disk_q       <= disk_number_i;
      par_q        <= disk_is_parallel_i;
      first_q      <= first_sector_i;
      last_q       <= last_sector_i;
      total_q      <= disk_sector_total_i;
      off_q        <= byte_offset_i;
      cnt_q        <= byte_count_i;
    end
    if (cmd_i.chk) begin
      bad_q    <= (first_q > last_q) || (first_q >= total_q) || (last_q >= total_q) ||
                  (ss == '0);
      lastp1_q <= last_q + 64'd1;
    end
    // Low half writes the partial product, high half adds the carry-in
    if (cmd_i.mul_en) begin
      if (!cmd_i.mul_hi) begin
        if (cmd_i.mul_end) end_q   <= {19'b0, mprod};
        else               start_q <= {19'b0, mprod};
      end else begin
        if (cmd_i.mul_end) begin
          end_q[63:32] <= msum[31:0];
          ovf_q        <= |msum[45:32];
        end else begin
          start_q[63:32] <= msum[31:0];
        end
      end
    end
    if (cmd_i.rd) begin
      nodev_q    <= !(acc_in_range && active_q[acc_sel]);
      rd_start_q <= start_arr_q[acc_sel];
      rd_len_q   <= len_arr_q[acc_sel];
      rd_disk_q  <= disk_arr_q[acc_sel];
      rd_par_q   <= par_arr_q[acc_sel];
    end
    if (cmd_i.acc_chk) begin
      past_q <= off_q >= rd_len_q;
      rem_q  <= rd_len_q - off_q;
    end
  end

  // Form the result
  always_ff @(posedge clk_i) begin
    case (cmd_i.fin)
      FinRange, FinFull, FinRemove: begin
        res_status_q <= (cmd_i.fin == FinRange) ? StatRange :
                        (cmd_i.fin == FinFull)  ? StatFull  : StatOk;
        res_slot_q   <= '0;
        res_addr_q   <= '0;
        res_xfer_q   <= '0;
        res_disk_q   <= '0;
        res_par_q    <= 1'b0;
      end
      FinRegister: begin
        res_status_q <= StatOk;
        res_slot_q   <= IdxW'(idx_q);
        res_addr_q   <= start_q;
        res_xfer_q   <= end_q - start_q;
        res_disk_q   <= disk_q;
        res_par_q    <= par_q;
      end
      FinAccess: begin
        res_slot_q <= slot_index_q;
        if (nodev_q || (past_q && is_write_q)) begin
          res_status_q <= nodev_q ? StatNoDev : StatNoSpc;
          res_addr_q   <= '0;
          res_xfer_q   <= '0;
          res_disk_q   <= '0;
          res_par_q    <= 1'b0;
        end else begin
          res_status_q <= StatOk;
          res_disk_q   <= rd_disk_q;
          res_par_q    <= rd_par_q;
          if (past_q) begin
            res_addr_q <= '0;
            res_xfer_q <= '0;
          end else begin
            res_addr_q <= rd_start_q + off_q;
            res_xfer_q <= (cnt_q > rem_q) ? rem_q : cnt_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_addr_q   <= res_addr_q;
      out_xfer_q   <= res_xfer_q;
      out_disk_q   <= res_disk_q;
      out_par_q    <= res_par_q;
    end
  end

  assign status_o             = out_status_q;
  assign slot_used_o          = out_slot_q;
  assign absolute_address_o   = out_addr_q;
  assign transfer_bytes_o     = out_xfer_q;
  assign target_disk_o        = out_disk_q;
  assign target_is_parallel_o = out_par_q;

endmodule

// ----- rtl/core/partition_window_table_core.sv -----
// Top level of the partition window table: stream ports, controller and datapath.
// Depends on pwt_pkg, pwt_ctrl and pwt_dp.
//
//   channel   | direction | tdata                                   | tuser
//   s_axis    | in        | slot, disk, kind, sectors, offset, count | mode
//   m_axis    | out       | slot, address, length, disk, kind       | status
//   cfg       | in        | sector size write (index 0 PATA, 1 SATA) | -
//
// One item at a time. Register runs the range check, four 32x13 multiplier steps
// and a scan for the first inactive slot; remove scans the appended slots; read
// and write read the addressed slot and check the offset against its length.
// Reset clears the slot store at once through its active bits and fill count.
// A finished result waits in the output register while the next item is taken;
// a stalled output holds the following result in the datapath.
module partition_window_table_core
  import pwt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // slot_index[7:0], disk_number[15:8], disk_is_parallel[16], first_sector[80:17],
  // last_sector[144:81], disk_sector_total[208:145], byte_offset[272:209],
  // byte_count[336:273], zero fill [343:337]
  input  logic [343:0]       s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // slot_used[7:0], absolute_address[71:8], transfer_bytes[135:72],
  // target_disk[143:136], target_is_parallel[144], zero fill [151:145]
  output logic [151:0]       m_axis_tdata,
  // status[2:0]
  output logic [2:0]         m_axis_tuser,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [SectorW-1:0] cfg_data_i
);

  pwt_cmd_t         cmd;
  pwt_stat_t        stat;
  mode_e            mode;
  status_e          status;
  logic [IdxW-1:0]  slot_used;
  logic [ByteW-1:0] abs_addr, xfer;
  logic [DiskW-1:0] tgt_disk;
  logic             tgt_par;

  assign mode = mode_e'(s_axis_tuser);

  pwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (mode),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pwt_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .mode_i               (mode),
    .slot_index_i         (s_axis_tdata[7:0]),
    .disk_number_i        (s_axis_tdata[15:8]),
    .disk_is_parallel_i   (s_axis_tdata[16]),
    .first_sector_i       (s_axis_tdata[80:17]),
    .last_sector_i        (s_axis_tdata[144:81]),
    .disk_sector_total_i  (s_axis_tdata[208:145]),
    .byte_offset_i        (s_axis_tdata[272:209]),
    .byte_count_i         (s_axis_tdata[336:273]),
    .status_o             (status),
    .slot_used_o          (slot_used),
    .absolute_address_o   (abs_addr),
    .transfer_bytes_o     (xfer),
    .target_disk_o        (tgt_disk),
    .target_is_parallel_o (tgt_par)
  );

  // Pack the result item
  assign m_axis_tdata = {7'b0, tgt_par, tgt_disk, xfer, abs_addr, slot_used};
  assign m_axis_tuser = status;

endmodule

// ----- bench/testbench.sv -----
// Testbench for partition_window_table_core: drives register, remove and access items
// over the stream ports, predicts every result and checks it. Depends on pwt_pkg.
`timescale 1ns / 1ps

module testbench
  import pwt_pkg::*;
();

  // What the driver does with one entry of its queue
  typedef enum logic [1:0] {
    JobItem,
    JobCfg,
    JobDrain
  } job_e;

  typedef struct {
    job_e               kind;
    mode_e              mode;
    logic [7:0]         slot;
    logic [7:0]         disk;
    logic               par;
    logic [63:0]        first;
    logic [63:0]        last;
    logic [63:0]        total;
    logic [63:0]        off;
    logic [63:0]        cnt;
    logic               cfg_idx;
    logic [SectorW-1:0] cfg_val;
  } job_t;

  typedef struct {
    status_e     status;
    logic [7:0]  slot;
    logic [63:0] addr;
    logic [63:0] bytes;
    logic [7:0]  disk;
    logic        par;
  } window_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [343:0]       s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [151:0]       m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = 1'b0;
  logic [SectorW-1:0] cfg_data_i = '0;

  partition_window_table_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted copy of the slot store and sector size registers
  logic               win_active [MaxSlots] = '{default: 1'b0};
  logic [7:0]         win_disk   [MaxSlots] = '{default: 8'd0};
  logic               win_par    [MaxSlots] = '{default: 1'b0};
  logic [63:0]        win_start  [MaxSlots] = '{default: 64'd0};
  logic [63:0]        win_len    [MaxSlots] = '{default: 64'd0};
  int                 win_fill = 0;
  logic [SectorW-1:0] pata_bytes = SectorReset;
  logic [SectorW-1:0] sata_bytes = SectorReset;

  job_t           pending [$];
  window_result_t expected_results [$];
  job_t           on_bus;
  int             n_sent = 0;
  int             n_checked = 0;
  int             n_errors = 0;
  logic           all_sent = 1'b0;
  logic           calm;

  // No idling on either side for a stretch of items
  assign calm = (n_sent >= 600) && (n_sent < 850);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Work out the result of one item and update the predicted store
  function automatic window_result_t translate_request(job_t j);
    window_result_t     r;
    logic [SectorW-1:0] ss;
    logic [63:0]        lim;
    logic [63:0]        len;
    logic [63:0]        cnt;
    int                 slot;
    int                 i;
    bit                 found;
    r.status = StatOk;
    r.slot   = '0;
    r.addr   = '0;
    r.bytes  = '0;
    r.disk   = '0;
    r.par    = 1'b0;
    case (j.mode)
      ModeRegister: begin
        ss  = j.par ? pata_bytes : sata_bytes;
        lim = '0;
        if (ss != '0) lim = 64'hFFFF_FFFF_FFFF_FFFF / 64'(ss);
        if (j.first > j.last || j.first >= j.total || j.last >= j.total || ss == '0 ||
            j.last + 64'd1 > lim) begin
          r.status = StatRange;
        end else begin
          found = 1'b0;
          slot  = 0;
          for (i = 0; i < win_fill; i++) begin
            if (!found && !win_active[i]) begin
              slot  = i;
              found = 1'b1;
            end
          end
          if (!found && win_fill >= MaxSlots) begin
            r.status = StatFull;
          end else begin
            if (!found) begin
              slot = win_fill;
              win_fill++;
            end
            win_active[slot] = 1'b1;
            win_disk[slot]   = j.disk;
            win_par[slot]    = j.par;
            win_start[slot]  = j.first * 64'(ss);
            win_len[slot]    = (j.last - j.first + 64'd1) * 64'(ss);
            r.slot  = 8'(slot);
            r.addr  = win_start[slot];
            r.bytes = win_len[slot];
            r.disk  = j.disk;
            r.par   = j.par;
          end
        end
      end
      ModeRemove: begin
        for (i = 0; i < win_fill; i++) begin
          if (win_active[i] && win_disk[i] == j.disk && win_par[i] == j.par)
            win_active[i] = 1'b0;
        end
      end
      default: begin
        r.slot = j.slot;
        if (int'(j.slot) >= win_fill) begin
          r.status = StatNoDev;
        end else if (!win_active[j.slot]) begin
          r.status = StatNoDev;
        end else begin
          len = win_len[j.slot];
          if (j.off >= len) begin
            if (j.mode == ModeWrite) begin
              r.status = StatNoSpc;
            end else begin
              r.disk = win_disk[j.slot];
              r.par  = win_par[j.slot];
            end
          end else begin
            cnt = (j.cnt > len - j.off) ? len - j.off : j.cnt;
            r.addr  = win_start[j.slot] + j.off;
            r.bytes = cnt;
            r.disk  = win_disk[j.slot];
            r.par   = win_par[j.slot];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h (result %0d)",
             field, got, want, n_checked);
    n_errors++;
  endtask

  // Driver: present queued items, write registers and wait for drains
  always @(posedge clk_i) begin : item_drive
    job_t j;
    logic next_valid;
    logic next_we;
    int   sent_now;
    if (rst_ni) begin
      next_valid = s_axis_tvalid;
      next_we    = 1'b0;
      sent_now   = n_sent;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(translate_request(on_bus));
        sent_now   = n_sent + 1;
        next_valid = 1'b0;
      end
      if (!next_valid && pending.size() != 0) begin
        j = pending[0];
        case (j.kind)
          JobDrain: begin
            if (n_checked == sent_now) void'(pending.pop_front());
          end
          JobCfg: begin
            next_we = 1'b1;
            cfg_index_i <= j.cfg_idx;
            cfg_data_i  <= j.cfg_val;
            if (j.cfg_idx == CfgPata) pata_bytes = j.cfg_val;
            else sata_bytes = j.cfg_val;
            void'(pending.pop_front());
          end
          default: begin
            if (calm || $urandom_range(99) >= 11) begin
              next_valid = 1'b1;
              on_bus     = j;
              s_axis_tdata <= {7'd0, j.cnt, j.off, j.total, j.last, j.first,
                               j.par, j.disk, j.slot};
              s_axis_tuser <= j.mode;
              void'(pending.pop_front());
            end
          end
        endcase
      end else if (!next_valid) begin
        all_sent <= 1'b1;
      end
      n_sent        <= sent_now;
      s_axis_tvalid <= next_valid;
      cfg_we_i      <= next_we;
    end
  end

  // Receiver: stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    window_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_axis_tuser), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        if (m_axis_tdata[7:0] != want.slot)
          report_mismatch("slot_used", 64'(m_axis_tdata[7:0]), 64'(want.slot));
        if (m_axis_tdata[71:8] != want.addr)
          report_mismatch("absolute_address", m_axis_tdata[71:8], want.addr);
        if (m_axis_tdata[135:72] != want.bytes)
          report_mismatch("transfer_bytes", m_axis_tdata[135:72], want.bytes);
        if (m_axis_tdata[143:136] != want.disk)
          report_mismatch("target_disk", 64'(m_axis_tdata[143:136]), 64'(want.disk));
        if (m_axis_tdata[144] != want.par)
          report_mismatch("target_is_parallel", 64'(m_axis_tdata[144]), 64'(want.par));
        n_checked <= n_checked + 1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Item with every field random
  function automatic job_t noise_item();
    job_t j;
    j.kind    = JobItem;
    j.mode    = mode_e'($urandom_range(3));
    j.slot    = 8'($urandom);
    j.disk    = 8'($urandom);
    j.par     = 1'($urandom);
    j.first   = rand64();
    j.last    = rand64();
    j.total   = rand64();
    j.off     = rand64();
    j.cnt     = rand64();
    j.cfg_idx = 1'b0;
    j.cfg_val = '0;
    return j;
  endfunction

  task automatic queue_register(logic [7:0] disk, logic par, logic [63:0] first,
                                logic [63:0] last, logic [63:0] total);
    job_t j;
    j       = noise_item();
    j.mode  = ModeRegister;
    j.disk  = disk;
    j.par   = par;
    j.first = first;
    j.last  = last;
    j.total = total;
    pending.push_back(j);
  endtask

  task automatic queue_remove(logic [7:0] disk, logic par);
    job_t j;
    j      = noise_item();
    j.mode = ModeRemove;
    j.disk = disk;
    j.par  = par;
    pending.push_back(j);
  endtask

  task automatic queue_access(mode_e mode, logic [7:0] slot, logic [63:0] off,
                              logic [63:0] cnt);
    job_t j;
    j      = noise_item();
    j.mode = mode;
    j.slot = slot;
    j.off  = off;
    j.cnt  = cnt;
    pending.push_back(j);
  endtask

  // Wait for the block to go idle, then write both sector sizes
  task automatic queue_settings(logic [SectorW-1:0] pata, logic [SectorW-1:0] sata);
    job_t j;
    j      = noise_item();
    j.kind = JobDrain;
    pending.push_back(j);
    j.kind    = JobCfg;
    j.cfg_idx = CfgPata;
    j.cfg_val = pata;
    pending.push_back(j);
    j.cfg_idx = CfgSata;
    j.cfg_val = sata;
    pending.push_back(j);
  endtask

  // Mostly well-formed windows on a few disks, accesses near the windows, some noise
  task automatic queue_random(int n);
    job_t j;
    int   pick;
    int   k;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      j    = noise_item();
      if (pick < 5) begin
        pending.push_back(j);
      end else if (pick < 35) begin
        j.mode = ModeRegister;
        j.disk = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        case ($urandom_range(9))
          0:       j.total = rand64();
          1:       j.total = '1;
          2:       j.total = 64'd1;
          default: j.total = 64'($urandom_range(2000, 1));
        endcase
        j.first = rand64() % j.total;
        if ($urandom_range(1)) j.last = j.first + 64'($urandom_range(64));
        else j.last = j.first + rand64() % (j.total - j.first);
        if (j.last >= j.total || j.last < j.first) j.last = j.total - 64'd1;
        // broken ranges now and then
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1)) j.last = j.total;
          else j.first = j.last + 64'd1;
        end
        pending.push_back(j);
      end else if (pick < 45) begin
        j.mode = ModeRemove;
        j.disk = 8'($urandom_range(3));
        pending.push_back(j);
      end else begin
        j.mode = (pick < 72) ? ModeRead : ModeWrite;
        j.slot = ($urandom_range(6) == 0) ? 8'($urandom) : 8'($urandom_range(17));
        case ($urandom_range(9))
          0:       j.off = rand64();
          1:       j.off = 64'($urandom_range(600000));
          default: j.off = 64'($urandom_range(5000));
        endcase
        case ($urandom_range(9))
          0:       j.cnt = '0;
          1:       j.cnt = '1;
          2, 3:    j.cnt = rand64();
          default: j.cnt = 64'($urandom_range(5000));
        endcase
        pending.push_back(j);
      end
      if ($urandom_range(99) == 0) begin
        j.kind = JobDrain;
        pending.push_back(j);
      end
    end
  endtask

  initial begin : stimulus
    int i;
    // Empty table, bad ranges and the window end overflow boundary
    queue_access(ModeRead, 8'd0, 64'd0, 64'd1);
    queue_register(8'd1, 1'b0, 64'd10, 64'd9, 64'd100);
    queue_register(8'd1, 1'b0, 64'd100, 64'd100, 64'd100);
    queue_register(8'd1, 1'b0, 64'd0, 64'd100, 64'd100);
    queue_register(8'd1, 1'b1, 64'd0, 64'h0080_0000_0000_0000, '1);
    queue_register(8'd255, 1'b1, 64'h007F_FFFF_FFFF_FFFE, 64'h007F_FFFF_FFFF_FFFE, '1);
    queue_register(8'd0, 1'b0, 64'd0, 64'd0, 64'd1);
    // Clamping, past-end read and write, top of the address space
    queue_access(ModeRead, 8'd0, 64'd0, '1);
    queue_access(ModeWrite, 8'd0, 64'd511, '1);
    queue_access(ModeWrite, 8'd0, 64'd512, 64'd1);
    queue_access(ModeRead, 8'd1, 64'd512, 64'd8);
    queue_access(ModeWrite, 8'd1, 64'd0, 64'd0);
    queue_access(ModeRead, 8'd255, 64'd0, 64'd1);
    // Fill the table, overflow it, then free slots and reuse the first hole
    for (i = 2; i <= MaxSlots; i++)
      queue_register(8'd255, 1'b1, 64'(i), 64'(i), 64'd100);
    queue_remove(8'd255, 1'b1);
    queue_register(8'd7, 1'b0, 64'd3, 64'd5, 64'd6);
    queue_access(ModeRead, 8'd3, 64'd0, 64'd1);

    queue_random(230);
    queue_settings(13'd1, 13'd4096);
    queue_random(230);
    queue_settings(13'd8191, 13'd0);
    queue_random(230);
    queue_settings(13'd0, 13'd1);
    queue_random(230);
    queue_settings(13'($urandom_range(4096, 1)), 13'($urandom_range(8191)));
    queue_random(230);
    queue_settings(13'd4096, 13'd8191);
    queue_random(230);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (all_sent && n_checked == n_sent);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pwt_pkg.sv
rtl/core/pwt_ctrl.sv
rtl/core/pwt_dp.sv
rtl/core/partition_window_table_core.sv
bench/testbench.sv
